// ===== rtl/core/hrhs_pkg.sv =====
package hrhs_pkg;

  localparam int POSITION_BITS_DEF = 16;

  localparam int LEN_NAME_SIZE = 16;
  localparam int LOC_NAME_SIZE = 10;

  localparam logic [7:0] LEN_NAME [LEN_NAME_SIZE] = '{
    8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
    8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a, 8'h20
  };
  localparam logic [7:0] LOC_NAME [LOC_NAME_SIZE] = '{
    8'h4c, 8'h6f, 8'h63, 8'h61, 8'h74, 8'h69, 8'h6f, 8'h6e, 8'h3a, 8'h20
  };

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_STATUS   = 2'd1;
  localparam logic [1:0] ERR_LENGTH   = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_COLLECT = 3'b010,
    PH_DONE    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  error_code;
    logic [15:0] status_code;
    logic [31:0] body_length;
    logic        location_found;
    logic [15:0] location_offset;
    logic [15:0] location_length;
  } out_rsp_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
  } status_sum_t;

  typedef struct packed {
    logic        done;
    logic [1:0]  err;
    logic [31:0] value;
  } length_sum_t;

  typedef struct packed {
    logic        done;
    logic [15:0] offset;
    logic [15:0] len;
  } location_sum_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

// ===== rtl/core/http_response_header_scan_core.sv =====
// http response header scanner
// in channel: one response byte per request (in_data.byte_in), with
//   in_data.last_byte marking the final byte of a message
// out channel: one result per message, holding the status code, the
//   content-length value, the location offset/length and an error code
// every byte is captured in an input register, then scanned from it by the status,
//   content-length and location trackers; a last byte loads the result register
// throughput: one byte per cycle while no last byte waits on a held result, set by the single scan stage
// receiver stall: the result register holds; bytes keep flowing until a
//   further last byte reaches the scan stage, which then waits in the input
//   register and holds in_ready low
// reset: synchronous, active low; clears both valid flags and returns all
//   trackers to the start-of-message state
module http_response_header_scan_core #(
  parameter int POSITION_BITS = hrhs_pkg::POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hrhs_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hrhs_pkg::out_rsp_t out_data
);

  logic                    s1_valid_r, s1_valid_nxt;
  hrhs_pkg::in_req_t       s1_data_r;
  logic                    out_valid_r, out_valid_nxt;
  hrhs_pkg::out_rsp_t      out_data_r, out_data_nxt;
  logic                    s1_go;
  logic                    emit;
  hrhs_pkg::status_sum_t   st_sum;
  hrhs_pkg::length_sum_t   len_sum;
  hrhs_pkg::location_sum_t loc_sum;

  assign s1_go    = s1_valid_r && (!s1_data_r.last_byte || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign emit     = s1_go && s1_data_r.last_byte;

  hrhs_status u_status (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .last    (s1_data_r.last_byte),
    .byte_in (s1_data_r.byte_in),
    .sum     (st_sum)
  );

  hrhs_length u_length (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .last    (s1_data_r.last_byte),
    .byte_in (s1_data_r.byte_in),
    .sum     (len_sum)
  );

  hrhs_location #(
    .POSITION_BITS (POSITION_BITS)
  ) u_location (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .last    (s1_data_r.last_byte),
    .byte_in (s1_data_r.byte_in),
    .sum     (loc_sum)
  );

  always_comb begin
    out_data_nxt = '0;
    if (!st_sum.ok) begin
      out_data_nxt.error_code = hrhs_pkg::ERR_STATUS;
    end else begin
      out_data_nxt.status_code = st_sum.value;
      if (len_sum.done && (len_sum.err != hrhs_pkg::ERR_OK)) begin
        out_data_nxt.error_code = len_sum.err;
      end else begin
        out_data_nxt.error_code = hrhs_pkg::ERR_OK;
        if (len_sum.done) out_data_nxt.body_length = len_sum.value;
        if (loc_sum.done) begin
          out_data_nxt.location_found  = 1'b1;
          out_data_nxt.location_offset = loc_sum.offset;
          out_data_nxt.location_length = loc_sum.len;
        end
      end
    end

    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
    if (emit) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/hrhs_status.sv =====
module hrhs_status (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  last,
  input  logic [7:0]            byte_in,
  output hrhs_pkg::status_sum_t sum
);

  hrhs_pkg::phase_t phase_r, phase_nxt, phase_upd;
  logic [15:0] value_r, value_nxt, value_upd;
  logic        seen_r, seen_nxt, seen_upd;
  logic        bad_r, bad_nxt, bad_upd;
  logic [19:0] value_x10;
  logic        is_ws;

  always_comb begin
    value_x10 = {1'b0, value_r, 3'b000} + {3'b000, value_r, 1'b0}
              + {12'd0, byte_in - hrhs_pkg::CH_ZERO};
    is_ws = (byte_in == hrhs_pkg::CH_SPACE) ||
            ((byte_in >= hrhs_pkg::CH_TAB) && (byte_in <= hrhs_pkg::CH_CR));
    phase_upd = phase_r;
    value_upd = value_r;
    seen_upd  = seen_r;
    bad_upd   = bad_r;
    case (phase_r)
      hrhs_pkg::PH_SEARCH: begin
        if (byte_in == hrhs_pkg::CH_SPACE) phase_upd = hrhs_pkg::PH_COLLECT;
      end
      hrhs_pkg::PH_COLLECT: begin
        if (byte_in == hrhs_pkg::CH_SPACE) begin
          phase_upd = hrhs_pkg::PH_DONE;
        end else if (hrhs_pkg::is_digit(byte_in)) begin
          value_upd = (value_x10 > 20'd65535) ? 16'hffff : value_x10[15:0];
          seen_upd  = 1'b1;
        end else if (!is_ws) begin
          bad_upd = 1'b1;
        end
      end
      default: begin
      end
    endcase

    sum.ok    = (phase_upd != hrhs_pkg::PH_SEARCH) && seen_upd && !bad_upd;
    sum.value = value_upd;

    phase_nxt = phase_r;
    value_nxt = value_r;
    seen_nxt  = seen_r;
    bad_nxt   = bad_r;
    if (step) begin
      if (last) begin
        phase_nxt = hrhs_pkg::PH_SEARCH;
        value_nxt = '0;
        seen_nxt  = 1'b0;
        bad_nxt   = 1'b0;
      end else begin
        phase_nxt = phase_upd;
        value_nxt = value_upd;
        seen_nxt  = seen_upd;
        bad_nxt   = bad_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrhs_pkg::PH_SEARCH;
      value_r <= '0;
      seen_r  <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      value_r <= value_nxt;
      seen_r  <= seen_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

// ===== rtl/core/hrhs_length.sv =====
module hrhs_length (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  last,
  input  logic [7:0]            byte_in,
  output hrhs_pkg::length_sum_t sum
);

  hrhs_pkg::phase_t phase_r, phase_nxt, phase_upd;
  logic [3:0]  idx_r, idx_nxt, idx_upd;
  logic [31:0] value_r, value_nxt, value_upd;
  logic [1:0]  err_r, err_nxt, err_upd;
  logic [35:0] value_x10;
  logic        hit;

  always_comb begin
    value_x10 = {1'b0, value_r, 3'b000} + {3'b000, value_r, 1'b0}
              + {28'd0, byte_in - hrhs_pkg::CH_ZERO};
    hit = (byte_in == hrhs_pkg::LEN_NAME[idx_r]);
    phase_upd = phase_r;
    idx_upd   = idx_r;
    value_upd = value_r;
    err_upd   = err_r;
    case (phase_r)
      hrhs_pkg::PH_SEARCH: begin
        if (hit && (idx_r == 4'(hrhs_pkg::LEN_NAME_SIZE - 1))) begin
          phase_upd = hrhs_pkg::PH_COLLECT;
          idx_upd   = '0;
        end else if (hit) begin
          idx_upd = idx_r + 4'd1;
        end else begin
          idx_upd = {3'b000, byte_in == hrhs_pkg::LEN_NAME[0]};
        end
      end
      hrhs_pkg::PH_COLLECT: begin
        if (byte_in == hrhs_pkg::CH_CR) begin
          phase_upd = hrhs_pkg::PH_DONE;
        end else if (hrhs_pkg::is_digit(byte_in)) begin
          if (value_x10[35:32] != 4'd0) begin
            value_upd = 32'hffff_ffff;
            if (err_r != hrhs_pkg::ERR_LENGTH) err_upd = hrhs_pkg::ERR_OVERFLOW;
          end else begin
            value_upd = value_x10[31:0];
          end
        end else begin
          err_upd = hrhs_pkg::ERR_LENGTH;
        end
      end
      default: begin
      end
    endcase

    sum.done  = (phase_upd == hrhs_pkg::PH_DONE);
    sum.err   = err_upd;
    sum.value = value_upd;

    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    value_nxt = value_r;
    err_nxt   = err_r;
    if (step) begin
      if (last) begin
        phase_nxt = hrhs_pkg::PH_SEARCH;
        idx_nxt   = '0;
        value_nxt = '0;
        err_nxt   = hrhs_pkg::ERR_OK;
      end else begin
        phase_nxt = phase_upd;
        idx_nxt   = idx_upd;
        value_nxt = value_upd;
        err_nxt   = err_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrhs_pkg::PH_SEARCH;
      idx_r   <= '0;
      value_r <= '0;
      err_r   <= hrhs_pkg::ERR_OK;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      value_r <= value_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== rtl/core/hrhs_location.sv =====
module hrhs_location #(
  parameter int POSITION_BITS = hrhs_pkg::POSITION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic                    last,
  input  logic [7:0]              byte_in,
  output hrhs_pkg::location_sum_t sum
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  hrhs_pkg::phase_t phase_r, phase_nxt, phase_upd;
  logic [3:0]               idx_r, idx_nxt, idx_upd;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_upd;
  logic [POSITION_BITS-1:0] start_r, start_nxt, start_upd;
  logic [POSITION_BITS-1:0] count_r, count_nxt, count_upd;
  logic                     hit;

  always_comb begin
    pos_upd   = (pos_r == POS_MAX) ? pos_r : pos_r + POSITION_BITS'(1);
    hit       = (byte_in == hrhs_pkg::LOC_NAME[idx_r]);
    phase_upd = phase_r;
    idx_upd   = idx_r;
    start_upd = start_r;
    count_upd = count_r;
    case (phase_r)
      hrhs_pkg::PH_SEARCH: begin
        if (hit && (idx_r == 4'(hrhs_pkg::LOC_NAME_SIZE - 1))) begin
          phase_upd = hrhs_pkg::PH_COLLECT;
          idx_upd   = '0;
          start_upd = pos_upd;
          count_upd = '0;
        end else if (hit) begin
          idx_upd = idx_r + 4'd1;
        end else begin
          idx_upd = {3'b000, byte_in == hrhs_pkg::LOC_NAME[0]};
        end
      end
      hrhs_pkg::PH_COLLECT: begin
        if (byte_in == hrhs_pkg::CH_CR) begin
          phase_upd = hrhs_pkg::PH_DONE;
        end else if (count_r != POS_MAX) begin
          count_upd = count_r + POSITION_BITS'(1);
        end
      end
      default: begin
      end
    endcase

    sum.done   = (phase_upd == hrhs_pkg::PH_DONE);
    sum.offset = 16'(start_upd);
    sum.len    = 16'(count_upd);

    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    count_nxt = count_r;
    if (step) begin
      if (last) begin
        phase_nxt = hrhs_pkg::PH_SEARCH;
        idx_nxt   = '0;
        pos_nxt   = '0;
        start_nxt = '0;
        count_nxt = '0;
      end else begin
        phase_nxt = phase_upd;
        idx_nxt   = idx_upd;
        pos_nxt   = pos_upd;
        start_nxt = start_upd;
        count_nxt = count_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrhs_pkg::PH_SEARCH;
      idx_r   <= '0;
      pos_r   <= '0;
      start_r <= '0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
